// ===== design/acac_pkg.sv =====
package acac_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam int IN_USE_W   = 5;
  localparam int WINDOW_W   = 6;
  localparam int BLINK_W    = 10;
  localparam int TIMEOUT_W  = 19;
  localparam int RING_W     = 16;

  // command codes
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_STOP      = 2'd2;
  localparam logic [1:0] CMD_COUNTDOWN = 2'd3;

  // screen action codes
  localparam logic [1:0] SCR_NONE  = 2'd0;
  localparam logic [1:0] SCR_ALARM = 2'd1;
  localparam logic [1:0] SCR_TIMER = 2'd2;
  localparam logic [1:0] SCR_BLANK = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALARMS_IN_USE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW_S   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_BLINK_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TIMEOUT_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_BLINK_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RING_MS    = 3'd5;

  localparam logic [IN_USE_W-1:0]  RST_ALARMS_IN_USE    = 5'd0;
  localparam logic [WINDOW_W-1:0]  RST_MATCH_WINDOW_S   = 6'd5;
  localparam logic [BLINK_W-1:0]   RST_ALARM_BLINK_MS   = 10'd500;
  localparam logic [TIMEOUT_W-1:0] RST_ALARM_TIMEOUT_MS = 19'd300000;
  localparam logic [BLINK_W-1:0]   RST_TIMER_BLINK_MS   = 10'd250;
  localparam logic [RING_W-1:0]    RST_TIMER_RING_MS    = 16'd5000;

  typedef struct packed {
    logic [4:0] hr;
    logic [5:0] mn;
    logic [6:0] days;
  } acac_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } acac_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
  } acac_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic slot_match;
    logic scan_last;
    logic out_free;
  } acac_sts_t;

endpackage

// ===== design/alarm_clock_alert_controller.sv =====
// Channel  | Direction | Handshake            | Payload
// in_      | slave     | in_tvalid/in_tready  | tuser command, tdata time and entry
// out_     | master    | out_tvalid/out_tready| tdata alert, ringing, slot, screen
// cfg_     | write     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// On a tick with no alarm ringing and alarms in use, the table scan reads one
// slot per cycle and ends at the first hit or at the last slot in use.
// Reset is synchronous and clears control state and table enable bits at once.
// The result waits in an output register; the next item is accepted meanwhile
// and holds in its last step until that register is free. cfg_ready stays high.
module alarm_clock_alert_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [1:0]                           in_tuser,  // command
  // hour, minute, second, weekday, entry_index, entry_enable, day_mask
  input  logic [acac_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // alert_level, alarm_ringing, ringing_slot, countdown_ringing, screen_action, zeros
  output logic [acac_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import acac_pkg::*;

  acac_cmd_t cmd;
  acac_sts_t sts;

  assign cfg_ready = 1'b1;

  acac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/acac_ctrl.sv =====
module acac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  acac_pkg::acac_sts_t sts,
  output acac_pkg::acac_cmd_t cmd
);
  import acac_pkg::*;

  acac_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.apply     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.need_scan) begin
          state_nxt = ST_APPLY;
        end else begin
          // one slot per cycle, stop at the first hit or the last slot in use
          cmd.scan_step = 1'b1;
          if (sts.slot_match || sts.scan_last) begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/acac_dp.sv =====
module acac_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [1:0]                           in_tuser,
  input  logic [acac_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 cfg_valid,
  input  logic [acac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acac_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  acac_pkg::acac_cmd_t                  cmd,
  output acac_pkg::acac_sts_t                  sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [acac_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import acac_pkg::*;

  // latched item
  logic [1:0]        op_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r;
  logic [5:0]        second_r;
  logic [2:0]        weekday_r;
  logic [3:0]        eidx_r;
  logic              een_r;
  logic [6:0]        emask_r;
  logic [SLOT_W-1:0] scan_idx_r;
  logic              hit_r;

  // alarm table: enable bits are reset, payload is not
  logic [TABLE_SLOTS-1:0] ten_r;
  acac_entry_t            tent_r [TABLE_SLOTS];

  // configuration
  logic [IN_USE_W-1:0]  in_use_r;
  logic [WINDOW_W-1:0]  window_r;
  logic [BLINK_W-1:0]   ablink_r;
  logic [TIMEOUT_W-1:0] atimeout_r;
  logic [BLINK_W-1:0]   tblink_r;
  logic [RING_W-1:0]    tring_r;

  // alert state
  logic                 aact_r, aact_nxt;
  logic [3:0]           aslot_r, aslot_nxt;
  logic [TIMEOUT_W-1:0] ring_el_r, ring_el_nxt;
  logic [BLINK_W-1:0]   acnt_r, acnt_nxt;
  logic                 aphase_r, aphase_nxt;
  logic                 cact_r, cact_nxt;
  logic [RING_W-1:0]    cel_r, cel_nxt;
  logic [BLINK_W-1:0]   ccnt_r, ccnt_nxt;
  logic                 cphase_r, cphase_nxt;
  logic [1:0]           screen_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  acac_entry_t       cur;
  logic [7:0]        days8;
  logic              wr_ok;
  logic [SLOT_W-1:0] wr_addr;

  assign cur   = tent_r[scan_idx_r];
  assign days8 = {1'b0, cur.days};
  assign wr_ok   = 32'(eidx_r) < TABLE_SLOTS;
  assign wr_addr = SLOT_W'(eidx_r);

  assign sts.need_scan  = (op_r == CMD_TICK) && !aact_r && (in_use_r != '0);
  assign sts.slot_match = ten_r[scan_idx_r] && (cur.hr == hour_r) && (cur.mn == minute_r) &&
                          (6'(second_r) < window_r) && (weekday_r != 3'd7) &&
                          days8[weekday_r];
  assign sts.scan_last  = (32'(scan_idx_r) + 32'd1 >= 32'(in_use_r)) ||
                          (32'(scan_idx_r) + 32'd1 >= TABLE_SLOTS);
  assign sts.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      hour_r    <= in_tdata[4:0];
      minute_r  <= in_tdata[10:5];
      second_r  <= in_tdata[16:11];
      weekday_r <= in_tdata[19:17];
      eidx_r    <= in_tdata[23:20];
      een_r     <= in_tdata[24];
      emask_r   <= in_tdata[31:25];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
    end else if (cmd.load) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
    end else if (cmd.scan_step) begin
      if (sts.slot_match) begin
        hit_r <= 1'b1;
      end else if (!sts.scan_last) begin
        scan_idx_r <= scan_idx_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ten_r <= '0;
    end else if (cmd.apply && (op_r == CMD_WRITE) && wr_ok) begin
      ten_r[wr_addr] <= een_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && (op_r == CMD_WRITE) && wr_ok) begin
      tent_r[wr_addr] <= '{hr: hour_r, mn: minute_r, days: emask_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= RST_ALARMS_IN_USE;
      window_r   <= RST_MATCH_WINDOW_S;
      ablink_r   <= RST_ALARM_BLINK_MS;
      atimeout_r <= RST_ALARM_TIMEOUT_MS;
      tblink_r   <= RST_TIMER_BLINK_MS;
      tring_r    <= RST_TIMER_RING_MS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALARMS_IN_USE:    in_use_r   <= cfg_data[IN_USE_W-1:0];
        CFG_MATCH_WINDOW_S:   window_r   <= cfg_data[WINDOW_W-1:0];
        CFG_ALARM_BLINK_MS:   ablink_r   <= cfg_data[BLINK_W-1:0];
        CFG_ALARM_TIMEOUT_MS: atimeout_r <= cfg_data[TIMEOUT_W-1:0];
        CFG_TIMER_BLINK_MS:   tblink_r   <= cfg_data[BLINK_W-1:0];
        CFG_TIMER_RING_MS:    tring_r    <= cfg_data[RING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    aact_nxt    = aact_r;
    aslot_nxt   = aslot_r;
    ring_el_nxt = ring_el_r;
    acnt_nxt    = acnt_r;
    aphase_nxt  = aphase_r;
    cact_nxt    = cact_r;
    cel_nxt     = cel_r;
    ccnt_nxt    = ccnt_r;
    cphase_nxt  = cphase_r;
    screen_nxt  = SCR_NONE;
    case (op_r)
      CMD_STOP: begin
        aact_nxt   = 1'b0;
        aslot_nxt  = '0;
        aphase_nxt = 1'b0;
        cact_nxt   = 1'b0;
        cphase_nxt = 1'b0;
      end
      CMD_COUNTDOWN: begin
        cact_nxt   = 1'b1;
        cel_nxt    = '0;
        ccnt_nxt   = '0;
        cphase_nxt = 1'b0;
      end
      CMD_TICK: begin
        if (hit_r) begin
          aact_nxt    = 1'b1;
          aslot_nxt   = 4'(32'(scan_idx_r));
          ring_el_nxt = '0;
          acnt_nxt    = '0;
          aphase_nxt  = 1'b0;
        end else if (aact_r) begin
          ring_el_nxt = (ring_el_r == '1) ? ring_el_r : ring_el_r + TIMEOUT_W'(1);
          acnt_nxt    = (acnt_r == '1) ? acnt_r : acnt_r + BLINK_W'(1);
          if (acnt_nxt > ablink_r) begin
            acnt_nxt   = '0;
            aphase_nxt = !aphase_r;
            screen_nxt = aphase_nxt ? SCR_ALARM : SCR_BLANK;
          end
          // timeout stops everything, the countdown included
          if (ring_el_nxt > atimeout_r) begin
            aact_nxt   = 1'b0;
            aslot_nxt  = '0;
            aphase_nxt = 1'b0;
            cact_nxt   = 1'b0;
            cphase_nxt = 1'b0;
          end
        end
        if (cact_nxt) begin
          cel_nxt = (cel_r == '1) ? cel_r : cel_r + RING_W'(1);
          if (cel_nxt < tring_r) begin
            ccnt_nxt = (ccnt_r == '1) ? ccnt_r : ccnt_r + BLINK_W'(1);
            if (ccnt_nxt > tblink_r) begin
              ccnt_nxt   = '0;
              cphase_nxt = !cphase_r;
              if (screen_nxt == SCR_NONE) begin
                screen_nxt = cphase_nxt ? SCR_TIMER : SCR_BLANK;
              end
            end
          end else begin
            cact_nxt   = 1'b0;
            cphase_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aact_r    <= 1'b0;
      aslot_r   <= '0;
      ring_el_r <= '0;
      acnt_r    <= '0;
      aphase_r  <= 1'b0;
      cact_r    <= 1'b0;
      cel_r     <= '0;
      ccnt_r    <= '0;
      cphase_r  <= 1'b0;
    end else if (cmd.apply) begin
      aact_r    <= aact_nxt;
      aslot_r   <= aslot_nxt;
      ring_el_r <= ring_el_nxt;
      acnt_r    <= acnt_nxt;
      aphase_r  <= aphase_nxt;
      cact_r    <= cact_nxt;
      cel_r     <= cel_nxt;
      ccnt_r    <= ccnt_nxt;
      cphase_r  <= cphase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_data_r <= {7'd0, screen_nxt, cact_nxt, (aact_nxt ? aslot_nxt : 4'd0), aact_nxt,
                     (aphase_nxt || cphase_nxt)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/acac_chk.sv =====
module acac_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [acac_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import acac_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item while busy");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[5:2] == 4'd0)
    else $error("slot reported with no alarm ringing");

  a_timer_banner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:7] == SCR_TIMER |-> out_tdata[6] && out_tdata[0])
    else $error("timer banner without countdown alert on");

endmodule

bind alarm_clock_alert_controller acac_chk u_chk (.*);
